// File: rtl/jnm_pkg.sv
`timescale 1ns / 1ps
// Package for the JSON nesting matcher: payload words, status codes and
// character constants. No dependencies.
package jnm_pkg;

  // Field widths fixed by the interface.
  localparam int unsigned LengthBits = 20;
  localparam int unsigned NestBits   = 7;
  localparam int unsigned LimitBits  = 7;

  // Depth limit after reset.
  localparam logic [LimitBits-1:0] DepthLimitReset = 7'd64;

  // Characters the scanner reacts to.
  localparam logic [7:0] CharLBrace    = 8'h7B;
  localparam logic [7:0] CharRBrace    = 8'h7D;
  localparam logic [7:0] CharLBrack    = 8'h5B;
  localparam logic [7:0] CharRBrack    = 8'h5D;
  localparam logic [7:0] CharQuote     = 8'h22;
  localparam logic [7:0] CharBackslash = 8'h5C;

  // Result status codes.
  typedef enum logic [2:0] {
    StIgnored  = 3'd0,
    StOpen     = 3'd1,
    StComplete = 3'd2,
    StMismatch = 3'd3,
    StUnterm   = 3'd4,
    StNotComp  = 3'd5,
    StDeep     = 3'd6
  } jnm_status_e;

  // One input word.
  typedef struct packed {
    logic [7:0] text_byte;
    logic       starts_value;
    logic       range_ends;
  } jnm_in_t;

  // One result word.
  typedef struct packed {
    jnm_status_e           status;
    logic [NestBits-1:0]   nest_level;
    logic                  inside_string;
    logic [LengthBits-1:0] value_length;
  } jnm_out_t;

endpackage

// File: rtl/jnm_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies; contents are not reset.
module jnm_ram #(
  parameter int unsigned WIDTH = 1,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port, and a read port that returns the old data on a collision.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/jnm_scan.sv
`timescale 1ns / 1ps
// Scanner state and one-byte step logic of the JSON nesting matcher.
// Depends on jnm_pkg and jnm_ram (stack entries below the top).
module jnm_scan import jnm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  jnm_in_t              in_i,
  input  logic [LimitBits-1:0] depth_limit_i,
  output jnm_out_t             res_o
);

  localparam int unsigned LvlW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned AddrW = $clog2(STACK_DEPTH);
  localparam int unsigned CmpW = (LvlW > LimitBits) ? LvlW : LimitBits;
  localparam logic [LvlW-1:0] LvlMax = LvlW'(STACK_DEPTH);
  localparam logic [LengthBits-1:0] LenMax = '1;

  // Control state.
  logic                  active_q, active_d;
  logic                  str_q, str_d;
  logic                  esc_q, esc_d;
  logic [LvlW-1:0]       level_q, level_d;
  logic                  top_q, top_d;
  logic [LengthBits-1:0] len_q, len_d;
  logic                  byp_q;
  logic                  byp_val_q;

  // Stack memory interface.
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic             rdata;
  logic             below;

  // Step working signals.
  logic            first;
  logic            last;
  logic [7:0]      b;
  logic            is_open;
  logic            is_close;
  logic [LvlW-1:0] level_base;
  logic            push_ok;
  logic [LvlW-1:0] lvl_out;
  logic [CmpW-1:0] lvl_ext;
  jnm_status_e     status;
  logic            in_str;
  logic            ignored;

  // Entries below the top of stack live in RAM; the top sits in top_q.
  jnm_ram #(
    .WIDTH(1),
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(top_q),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  // The entry just pushed into RAM is forwarded until the read catches up.
  assign below = byp_q ? byp_val_q : rdata;

  assign first    = in_i.starts_value;
  assign last     = in_i.range_ends;
  assign b        = in_i.text_byte;
  assign is_open  = (b == CharLBrace) || (b == CharLBrack);
  assign is_close = (b == CharRBrace) || (b == CharRBrack);

  // A push is allowed below both the configured limit and the stack size.
  assign level_base = first ? '0 : level_q;
  assign push_ok = (CmpW'(level_base) < CmpW'(depth_limit_i)) && (level_base < LvlMax);

  // Next state and result for one byte.
  always_comb begin
    active_d = active_q;
    str_d    = str_q;
    esc_d    = esc_q;
    level_d  = level_q;
    top_d    = top_q;
    len_d    = len_q;
    we       = 1'b0;
    status   = StOpen;
    lvl_out  = level_q;
    in_str   = 1'b0;
    ignored  = 1'b0;
    if (!step_i) begin
      ignored = 1'b1;
    end else if (first) begin
      // A first byte always abandons what was open and starts over.
      active_d = 1'b0;
      str_d    = 1'b0;
      esc_d    = 1'b0;
      level_d  = '0;
      len_d    = LengthBits'(1);
      lvl_out  = '0;
      if (!is_open) begin
        status = StNotComp;
      end else if (push_ok) begin
        active_d = 1'b1;
        level_d  = LvlW'(1);
        top_d    = (b == CharLBrace);
        lvl_out  = LvlW'(1);
      end else begin
        status = StDeep;
      end
    end else if (!active_q) begin
      ignored = 1'b1;
    end else begin
      if (len_q != LenMax) begin
        len_d = len_q + LengthBits'(1);
      end
      if (str_q) begin
        in_str = 1'b1;
        if (esc_q) begin
          esc_d = 1'b0;
        end else if (b == CharBackslash) begin
          esc_d = 1'b1;
        end else if (b == CharQuote) begin
          str_d = 1'b0;
        end
      end else if (b == CharQuote) begin
        in_str = 1'b1;
        str_d  = 1'b1;
      end else if (is_open) begin
        if (push_ok) begin
          we      = 1'b1;
          level_d = level_q + LvlW'(1);
          top_d   = (b == CharLBrace);
          lvl_out = level_q + LvlW'(1);
        end else begin
          status   = StDeep;
          active_d = 1'b0;
          str_d    = 1'b0;
          esc_d    = 1'b0;
          level_d  = '0;
        end
      end else if (is_close) begin
        if ((level_q == '0) || (top_q != (b == CharRBrace))) begin
          status   = StMismatch;
          active_d = 1'b0;
          str_d    = 1'b0;
          esc_d    = 1'b0;
          level_d  = '0;
        end else begin
          level_d = level_q - LvlW'(1);
          lvl_out = level_q - LvlW'(1);
          top_d   = below;
          if (level_q == LvlW'(1)) begin
            status   = StComplete;
            active_d = 1'b0;
          end
        end
      end
    end
    // Running out of text with the value still open, first byte included.
    if (step_i && active_d && last) begin
      status   = StUnterm;
      lvl_out  = level_d;
      active_d = 1'b0;
      str_d    = 1'b0;
      esc_d    = 1'b0;
      level_d  = '0;
    end
  end

  // The old top goes into RAM on a push; the entry under the next top is prefetched.
  assign waddr = AddrW'(level_q - LvlW'(1));
  assign raddr = AddrW'(level_d - LvlW'(2));

  // Result word.
  assign lvl_ext = CmpW'(lvl_out);
  always_comb begin
    if (ignored) begin
      res_o = '0;
      res_o.status = StIgnored;
    end else begin
      res_o.status        = status;
      res_o.nest_level    = lvl_ext[NestBits-1:0];
      res_o.inside_string = in_str;
      res_o.value_length  = len_d;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      str_q    <= 1'b0;
      esc_q    <= 1'b0;
      level_q  <= '0;
      top_q    <= 1'b0;
      len_q    <= '0;
      byp_q    <= 1'b0;
    end else begin
      if (step_i) begin
        active_q <= active_d;
        str_q    <= str_d;
        esc_q    <= esc_d;
        level_q  <= level_d;
        top_q    <= top_d;
        len_q    <= len_d;
      end
      byp_q <= we;
    end
  end

  // Forwarded copy of the entry written on a push.
  always_ff @(posedge clk_i) begin
    if (we) begin
      byp_val_q <= top_q;
    end
  end

  // An idle scanner holds no depth and no string state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !active_q |-> (level_q == '0) && !str_q && !esc_q)
    else $error("idle scanner holds stale state");

  // An open value always has at least one closer pending.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (level_q != '0) && (level_q <= LvlMax))
    else $error("open value with bad depth");

  // An escape is only pending inside a string.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q |-> str_q)
    else $error("escape pending outside a string");

endmodule

// File: rtl/json_nesting_matcher_top.sv
`timescale 1ns / 1ps
// A result word is valid in the cycle after its byte is accepted.
// One byte per cycle while the result register is free or being emptied;
// the stack top is a flop; the entry beneath it is prefetched from the RAM.
// Reset: control state clears and depth_limit returns to 64; the stack RAM
// is not cleared, since only entries written in the current value are read.
// Top level of the JSON nesting matcher. Depends on jnm_pkg and jnm_scan.
module json_nesting_matcher_top import jnm_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 64
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  jnm_in_t              in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output jnm_out_t             out_word_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [LimitBits-1:0] cfg_data_i
);

  logic                 acc;
  logic                 out_valid_q, out_valid_d;
  jnm_out_t             out_q;
  jnm_out_t             res;
  logic [LimitBits-1:0] depth_limit_q;

  // A word is taken whenever the result register is free or being emptied.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign acc         = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  jnm_scan #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .step_i       (acc),
    .in_i         (in_word_i),
    .depth_limit_i(depth_limit_q),
    .res_o        (res)
  );

  // Result register valid flag.
  always_comb begin
    if (acc) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control and configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q   <= 1'b0;
      depth_limit_q <= DepthLimitReset;
    end else begin
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        depth_limit_q <= cfg_data_i;
      end
    end
  end

  // Result payload register.
  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

  // Every accepted byte yields a result word in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> out_valid_o)
    else $error("accepted byte produced no result");

  // A waiting result word holds its payload until it is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_word_o))
    else $error("result word changed while waiting");

  // An empty result register never blocks the input.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result register");

endmodule
